>>> rtl/gdil_pkg.sv
// Shared types, codes and defaults for the 3x3 grayscale dilation block.
package gdil_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 8;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam int MAX_WIDTH_DEF = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  localparam logic [CFG_W-1:0] WIDTH_RST = CFG_W'(16);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(16);

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_WIDTH = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic cmd;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic frame_end;
  } out_t;

  // Per-step controls handed from the counters to the window stage.
  typedef struct packed {
    logic center2;  // row start: take the max before the new column shifts in
    logic top;      // row above is inside the image
    logic bot;      // row below is inside the image
    logic left;     // column to the left is inside the image
    logic right;    // column to the right is inside the image
    logic emit;     // step produces a result beat
    logic fe;       // result is the last of the frame
  } win_ctrl_t;

endpackage

>>> rtl/gdil_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gdil_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/gdil_ctrl.sv
// Raster position counters, command decode and line buffer read issue.
module gdil_ctrl import gdil_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CFG_W-1:0]      cfg_width_i,
  input  logic [CFG_W-1:0]      cfg_height_i,
  input  logic                  restart_i,
  input  logic                  in_valid_i,
  input  in_t                   in_data_i,
  output logic                  in_stall_o,
  input  logic                  win_ready_i,
  output logic                  item_valid_o,
  output win_ctrl_t             item_ctrl_o,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] item_col_o,
  output logic [PIX_W-1:0]      item_pixel_o,
  output logic                  rd_en_o,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr_o
);

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RowW = $clog2(MAX_HEIGHT + 2);

  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [RowW-1:0] h_row;
  logic [ColW-1:0] ic_q, ic_d, oc_q, oc_d;
  logic [RowW-1:0] ir_q, ir_d, or_q, or_d;
  logic            redo_q, redo_d;
  logic            take, fire, act, emit, fe;
  logic            cmd;
  logic [PIX_W-1:0] pix;
  logic            input_done;
  logic [WW-1:0]   ic_inc, oc_inc;
  logic [RowW-1:0] or_inc;
  logic            col_last, ocol_last;

  // Saturate the configured size to the supported range.
  always_comb begin
    if (cfg_width_i == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_i) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_i);
    end
    if (cfg_height_i == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_height_i) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height_i);
    end
  end

  assign h_row = RowW'(h_eff);

  // A drain that opens the drain of a one-row frame needs a silent step first;
  // hold the input meanwhile and replay it as a second drain step.
  assign in_stall_o = redo_q || !win_ready_i;
  assign take = in_valid_i && !in_stall_o;
  assign fire = take || (redo_q && win_ready_i);
  assign cmd = redo_q ? CMD_DRAIN : in_data_i.cmd;
  assign pix = redo_q ? '0 : in_data_i.pixel;

  assign input_done = ir_q >= h_row;
  assign act = fire && ((cmd == CMD_PIXEL) ? !input_done : input_done);

  assign ic_inc = WW'(ic_q) + WW'(1);
  assign oc_inc = WW'(oc_q) + WW'(1);
  assign or_inc = or_q + RowW'(1);
  assign col_last = ic_inc >= w_eff;
  assign ocol_last = oc_inc >= w_eff;

  assign emit = ((ir_q >= RowW'(2)) || (ir_q == RowW'(1) && ic_q != '0)) && (or_q < h_row);
  assign fe = emit && ocol_last && (or_inc >= h_row);

  always_comb begin
    ic_d = ic_q;
    ir_d = ir_q;
    oc_d = oc_q;
    or_d = or_q;
    redo_d = redo_q;
    if (fire) begin
      redo_d = act && (cmd == CMD_DRAIN) && !emit;
    end
    if (restart_i) begin
      ic_d = '0;
      ir_d = '0;
      oc_d = '0;
      or_d = '0;
      redo_d = 1'b0;
    end else if (act) begin
      if (fe) begin
        ic_d = '0;
        ir_d = '0;
        oc_d = '0;
        or_d = '0;
      end else begin
        if (col_last) begin
          ic_d = '0;
          ir_d = ir_q + RowW'(1);
        end else begin
          ic_d = ColW'(ic_inc);
        end
        if (emit) begin
          if (ocol_last) begin
            oc_d = '0;
            or_d = or_inc;
          end else begin
            oc_d = ColW'(oc_inc);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= '0;
      ir_q <= '0;
      oc_q <= '0;
      or_q <= '0;
      redo_q <= 1'b0;
    end else begin
      ic_q <= ic_d;
      ir_q <= ir_d;
      oc_q <= oc_d;
      or_q <= or_d;
      redo_q <= redo_d;
    end
  end

  assign item_valid_o = act;
  assign item_col_o = ic_q;
  assign item_pixel_o = pix;
  assign item_ctrl_o.center2 = (ic_q == '0);
  assign item_ctrl_o.top = (or_q != '0);
  assign item_ctrl_o.bot = (or_inc < h_row);
  assign item_ctrl_o.left = (oc_q != '0);
  assign item_ctrl_o.right = (oc_inc < w_eff);
  assign item_ctrl_o.emit = emit;
  assign item_ctrl_o.fe = fe;
  assign rd_en_o = act;
  assign rd_addr_o = ic_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_o |-> win_ready_i)
    else $error("step issued while the window stage is full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (redo_q && win_ready_i) |=> !redo_q)
    else $error("drain replay repeated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_o && item_ctrl_o.fe && !restart_i) |=>
      (ic_q == '0 && ir_q == '0 && oc_q == '0 && or_q == '0))
    else $error("counters not cleared after the last beat of a frame");

endmodule

>>> rtl/gdil_win.sv
// Window stage: column window, 3x3 max, line buffer write back, result register.
module gdil_win import gdil_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  logic                  item_valid_i,
  input  win_ctrl_t             item_ctrl_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] item_col_i,
  input  logic [PIX_W-1:0]      item_pixel_i,
  output logic                  ready_o,
  input  logic [2*PIX_W-1:0]    rd_data_i,
  output logic                  wr_en_o,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_addr_o,
  output logic [2*PIX_W-1:0]    wr_data_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o
);

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                    s1_valid_q;
  win_ctrl_t               s1_ctrl_q;
  logic [ColW-1:0]         s1_col_q;
  logic [PIX_W-1:0]        s1_pix_q;
  logic                    byp_q;
  logic [2*PIX_W-1:0]      byp_data_q;
  logic [2:0][PIX_W-1:0]   wa_q, wb_q, nc;
  logic [2*PIX_W-1:0]      line;
  logic                    go;
  logic [2:0]              row_on;
  logic [PIX_W-1:0]        m_a, m_b, m_n, m_all;
  logic                    out_valid_q;
  out_t                    out_q;

  function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  assign go = s1_valid_q && (!s1_ctrl_q.emit || !out_valid_q || !out_stall_i);
  assign ready_o = !s1_valid_q || go;

  // Forward the write of the same cycle when the read hit the same column.
  assign line = byp_q ? byp_data_q : rd_data_i;
  assign nc[0] = line[2*PIX_W-1:PIX_W];
  assign nc[1] = line[PIX_W-1:0];
  assign nc[2] = s1_pix_q;

  assign wr_en_o = go;
  assign wr_addr_o = s1_col_q;
  assign wr_data_o = {nc[1], s1_pix_q};

  // Out-of-image values drop to zero, which never wins against the center.
  assign row_on = {s1_ctrl_q.bot, 1'b1, s1_ctrl_q.top};
  always_comb begin
    m_a = max3(wa_q[0] & {PIX_W{row_on[0]}}, wa_q[1], wa_q[2] & {PIX_W{row_on[2]}});
    m_b = max3(wb_q[0] & {PIX_W{row_on[0]}}, wb_q[1], wb_q[2] & {PIX_W{row_on[2]}});
    m_n = max3(nc[0] & {PIX_W{row_on[0]}}, nc[1], nc[2] & {PIX_W{row_on[2]}});
    m_all = max3(m_a & {PIX_W{s1_ctrl_q.left}}, m_b,
                 m_n & {PIX_W{!s1_ctrl_q.center2 && s1_ctrl_q.right}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      wa_q <= '0;
      wb_q <= '0;
    end else begin
      if (item_valid_i) begin
        s1_valid_q <= 1'b1;
      end else if (go) begin
        s1_valid_q <= 1'b0;
      end

      if (restart_i) begin
        wa_q <= '0;
        wb_q <= '0;
      end else if (go) begin
        if (s1_ctrl_q.fe) begin
          wa_q <= '0;
          wb_q <= '0;
        end else begin
          wa_q <= wb_q;
          wb_q <= nc;
        end
      end

      if (go && s1_ctrl_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      s1_ctrl_q <= item_ctrl_i;
      s1_col_q <= item_col_i;
      s1_pix_q <= item_pixel_i;
      byp_q <= go && (s1_col_q == item_col_i);
      byp_data_q <= wr_data_o;
    end
    if (go && s1_ctrl_q.emit) begin
      out_q.out_pixel <= m_all;
      out_q.frame_end <= s1_ctrl_q.fe;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i |-> ready_o)
    else $error("window stage overwritten while holding a step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && s1_ctrl_q.fe) |=> (wa_q == '0 && wb_q == '0))
    else $error("window not cleared after the last beat of a frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && s1_ctrl_q.emit) |=> (out_valid_o && out_data_o.frame_end == $past(s1_ctrl_q.fe)))
    else $error("result register missed an emitted beat");

endmodule

>>> rtl/grayscale_dilation_3x3.sv
// Top level of the 3x3 grayscale dilation block: register port and stage wiring.
// Takes one raster pixel or drain command per clock unless in_stall_o is set,
// and returns each pixel replaced by the maximum of its in-image 3x3
// neighbourhood. Results trail the input by width+1 pixels; after the last
// pixel of a frame, one drain command (cmd=1) per remaining result flushes the
// rest, and the final result carries frame_end. Throughput is one beat per
// cycle, set by the single line buffer RAM (one read and one write per cycle),
// except when back-pressure or a one-row frame's first drain holds the input.
// Results pass the window stage and result registers. Line buffer
// contents survive reset and need no clearing. Writing image_width or
// image_height restarts the frame; write them only while the block is idle.
// Sizes outside 1..MAX_WIDTH and 1..MAX_HEIGHT are saturated.
module grayscale_dilation_3x3 import gdil_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [CFG_W-1:0]   width_q, height_q;
  logic               cfg_we;
  reg_idx_e           reg_idx;
  logic               win_ready;
  logic               item_valid;
  win_ctrl_t          item_ctrl;
  logic [ColW-1:0]    item_col;
  logic [PIX_W-1:0]   item_pixel;
  logic               rd_en, wr_en;
  logic [ColW-1:0]    rd_addr, wr_addr;
  logic [2*PIX_W-1:0] rd_data, wr_data;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_WIDTH:  width_q <= pwdata[CFG_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:    prdata = '0;
    endcase
  end

  gdil_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_width_i (width_q),
    .cfg_height_i(height_q),
    .restart_i   (cfg_we),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .win_ready_i (win_ready),
    .item_valid_o(item_valid),
    .item_ctrl_o (item_ctrl),
    .item_col_o  (item_col),
    .item_pixel_o(item_pixel),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr)
  );

  // Above and current rows of one column share an entry.
  gdil_ram #(
    .Width(2 * PIX_W),
    .Depth(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  gdil_win #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we),
    .item_valid_i(item_valid),
    .item_ctrl_i (item_ctrl),
    .item_col_i  (item_col),
    .item_pixel_i(item_pixel),
    .ready_o     (win_ready),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> verif/grayscale_dilation_3x3_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 grayscale dilation stream block.
module grayscale_dilation_3x3_tb;
  import gdil_pkg::*;

  localparam int RAND_ITEMS = 1700;
  localparam int SETTLE_CYC = 8;
  localparam int DIR_ROWS = 26;

  // One row of the directed table: a register write or an input beat.
  typedef struct packed {
    logic             wr;
    reg_idx_e         sel;
    logic [PIX_W-1:0] value;    // register value or pixel
    cmd_e             cmd;
    logic             lit;      // result typed in below
    out_t             lit_res;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  grayscale_dilation_3x3 dut (.*);

  // Shadow of the block: registers, line buffers, counters and window.
  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic [PIX_W-1:0] line_above [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] line_cur [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] win [3][3];
  int unsigned      in_col, in_row, out_col, out_row;

  out_t dilated_q [$];
  out_t want;
  int   mismatches = 0;
  bit   gaps_on = 1'b0;
  bit   stalls_on = 1'b0;
  int   stall_left = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b1, REG_WIDTH,  8'd1,   CMD_PIXEL, 1'b0, 9'h0},
    '{1'b1, REG_HEIGHT, 8'd1,   CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'hff,  CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h00,  CMD_DRAIN, 1'b1, {8'hff, 1'b1}},
    // frame already restarted: drain is dropped
    '{1'b0, REG_WIDTH,  8'h00,  CMD_DRAIN, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h00,  CMD_PIXEL, 1'b0, 9'h0},
    // input complete: extra pixel is dropped
    '{1'b0, REG_WIDTH,  8'ha5,  CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h00,  CMD_DRAIN, 1'b1, {8'h00, 1'b1}},
    '{1'b0, REG_WIDTH,  8'h5a,  CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h00,  CMD_DRAIN, 1'b1, {8'h5a, 1'b1}},
    // zero width saturates to one
    '{1'b1, REG_WIDTH,  8'd0,   CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'ha5,  CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h00,  CMD_DRAIN, 1'b1, {8'ha5, 1'b1}},
    '{1'b1, REG_WIDTH,  8'd3,   CMD_PIXEL, 1'b0, 9'h0},
    '{1'b1, REG_HEIGHT, 8'd2,   CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h10,  CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'hff,  CMD_PIXEL, 1'b0, 9'h0},
    // drain in mid-frame is dropped
    '{1'b0, REG_WIDTH,  8'h33,  CMD_DRAIN, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h00,  CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h01,  CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h80,  CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h7f,  CMD_PIXEL, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h00,  CMD_DRAIN, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h00,  CMD_DRAIN, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h00,  CMD_DRAIN, 1'b0, 9'h0},
    '{1'b0, REG_WIDTH,  8'h00,  CMD_DRAIN, 1'b0, 9'h0}
  };

  function automatic int unsigned dim_eff(logic [CFG_W-1:0] raw, int unsigned lim);
    if (raw == 0) return 1;
    if (32'(raw) > lim) return lim;
    return 32'(raw);
  endfunction

  function automatic void frame_restart();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    foreach (win[r, c]) win[r][c] = '0;
  endfunction

  function automatic void shift_in(int unsigned col, logic [PIX_W-1:0] p);
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_above[col];
    win[1][2] = line_cur[col];
    win[2][2] = p;
    line_above[col] = line_cur[col];
    line_cur[col] = p;
  endfunction

  // Max over the in-image part of the window around column 'center'.
  function automatic logic [PIX_W-1:0] neigh_max(int center, int unsigned w, int unsigned h);
    int r0, r1, c0, c1;
    logic [PIX_W-1:0] m;
    r0 = (out_row >= 1) ? 0 : 1;
    r1 = (out_row + 1 < h) ? 2 : 1;
    c0 = (out_col >= 1) ? center - 1 : center;
    c1 = (out_col + 1 < w && center < 2) ? center + 1 : center;
    m = win[1][center];
    for (int r = r0; r <= r1; r++)
      for (int c = c0; c <= c1; c++)
        if (win[r][c] > m) m = win[r][c];
    return m;
  endfunction

  // Advance one raster position, real pixel or flush filler.
  function automatic bit raster_advance(logic [PIX_W-1:0] p, output out_t res);
    int unsigned w, h, ic;
    bit emit;
    logic [PIX_W-1:0] v;
    w = dim_eff(cfg_width, MAX_WIDTH_DEF);
    h = dim_eff(cfg_height, MAX_HEIGHT_DEF);
    ic = in_col;
    emit = (in_row >= 2 || (in_row == 1 && ic >= 1)) && out_row < h;
    v = '0;
    res = '0;
    if (ic == 0) begin
      if (emit) v = neigh_max(2, w, h);
      shift_in(ic, p);
    end else begin
      shift_in(ic, p);
      if (emit) v = neigh_max(1, w, h);
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return 1'b0;
    res.out_pixel = v;
    res.frame_end = (out_row == h - 1 && out_col == w - 1);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (res.frame_end) frame_restart();
    return 1'b1;
  endfunction

  function automatic bit dilate_predict(in_t item, output out_t res);
    int unsigned h;
    h = dim_eff(cfg_height, MAX_HEIGHT_DEF);
    res = '0;
    if (item.cmd == CMD_PIXEL) begin
      if (in_row >= h) return 1'b0;
      return raster_advance(item.pixel, res);
    end
    if (in_row < h) return 1'b0;
    for (int i = 0; i < 2; i++)
      if (raster_advance('0, res)) return 1'b1;
    return 1'b0;
  endfunction

  task automatic send_beat(in_t item, logic lit, out_t lit_res);
    int gap;
    out_t res;
    bit got;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = dilate_predict(item, res);
    if (lit) dilated_q.push_back(lit_res);
    else if (got) dilated_q.push_back(res);
  endtask

  // Drop valid and wait for the block to go quiet.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (dilated_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic read_reg(reg_idx_e sel, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_ADDR_W'(4 * int'(sel));
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== APB_DATA_W'(val)) begin
      $display("%0t: register %s readback, expected %0h, got %0h", $time, sel.name(),
               val, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(reg_idx_e sel, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(sel));
    pwdata <= APB_DATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (sel == REG_WIDTH) cfg_width = val;
    else cfg_height = val;
    frame_restart();
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    read_reg(sel, val);
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
    out_stall_i <= stalls_on && stall_left > 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dilated_q.size() == 0) begin
        $display("%0t: result beat with none expected, got pixel %02h frame_end %0b",
                 $time, out_data_o.out_pixel, out_data_o.frame_end);
        mismatches++;
      end else begin
        want = dilated_q.pop_front();
        if (out_data_o.out_pixel !== want.out_pixel) begin
          $display("%0t: out_pixel expected %02h, got %02h", $time, want.out_pixel,
                   out_data_o.out_pixel);
          mismatches++;
        end
        if (out_data_o.frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end,
                   out_data_o.frame_end);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_t beat;
    int unsigned w, h, cut;
    logic [CFG_W-1:0] raw_w, raw_h;
    int style, pattern, cfg_round, work, k;
    bit need_cfg;

    cfg_width = WIDTH_RST;
    cfg_height = HEIGHT_RST;
    foreach (line_above[i]) begin
      line_above[i] = '0;
      line_cur[i] = '0;
    end
    frame_restart();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    read_reg(REG_WIDTH, WIDTH_RST);
    read_reg(REG_HEIGHT, HEIGHT_RST);

    gaps_on = 1'b1;
    stalls_on = 1'b1;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) begin
        settle();
        set_reg(dir_tab[i].sel, dir_tab[i].value);
      end else begin
        beat.cmd = dir_tab[i].cmd;
        beat.pixel = dir_tab[i].value;
        send_beat(beat, dir_tab[i].lit, dir_tab[i].lit_res);
      end
    end

    cfg_round = 0;
    need_cfg = 1'b1;
    work = 0;
    while (work < RAND_ITEMS) begin
      if (work > RAND_ITEMS * 85 / 100) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        gaps_on = 1'($urandom_range(0, 1));
        stalls_on = 1'($urandom_range(0, 1));
      end

      if (need_cfg || $urandom_range(0, 2) == 0) begin
        case (cfg_round)
          0: begin raw_w = 8'd255; raw_h = 8'd2; end
          1: begin raw_w = 8'd2; raw_h = 8'd128; end
          2: begin raw_w = 8'd128; raw_h = 8'd0; end
          default: begin
            case ($urandom_range(0, 29))
              0: begin
                raw_w = 8'd128;
                raw_h = 8'($urandom_range(1, 3));
              end
              1: begin
                raw_w = 8'($urandom_range(1, 3));
                raw_h = 8'd128;
              end
              2: begin
                raw_w = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(129, 255));
                raw_h = 8'($urandom_range(1, 4));
              end
              3: begin
                raw_w = 8'($urandom_range(1, 4));
                raw_h = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(129, 255));
              end
              4: begin raw_w = 8'd1; raw_h = 8'd1; end
              default: begin
                raw_w = 8'($urandom_range(1, 12));
                raw_h = 8'($urandom_range(1, 12));
              end
            endcase
          end
        endcase
        cfg_round++;
        settle();
        set_reg(REG_WIDTH, raw_w);
        set_reg(REG_HEIGHT, raw_h);
        need_cfg = 1'b0;
      end

      w = dim_eff(cfg_width, MAX_WIDTH_DEF);
      h = dim_eff(cfg_height, MAX_HEIGHT_DEF);
      // 0: abandon during pixels, 1: abandon during flush, 2: noisy, else clean
      style = $urandom_range(0, 11);
      pattern = $urandom_range(0, 2);
      cut = (style == 0) ? $urandom_range(0, w * h - 1) : w * h;
      for (k = 0; k < cut; k++) begin
        if (style == 2 && $urandom_range(0, 7) == 0) begin
          beat.cmd = CMD_DRAIN;
          beat.pixel = 8'($urandom);
          send_beat(beat, 1'b0, '0);
        end
        beat.cmd = CMD_PIXEL;
        case (pattern)
          0: beat.pixel = 8'($urandom);
          1: beat.pixel = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00;
          default: beat.pixel = ($urandom_range(0, 15) == 0) ? 8'hff
                                                                : 8'($urandom_range(0, 15));
        endcase
        send_beat(beat, 1'b0, '0);
        work++;
      end
      if (style == 2) begin
        repeat ($urandom_range(1, 3)) begin
          beat.cmd = CMD_PIXEL;
          beat.pixel = 8'($urandom);
          send_beat(beat, 1'b0, '0);
        end
      end
      cut = (style == 0) ? 0 : (style == 1) ? $urandom_range(0, w) : w + 1;
      for (k = 0; k < cut; k++) begin
        beat.cmd = CMD_DRAIN;
        beat.pixel = 8'($urandom);
        send_beat(beat, 1'b0, '0);
        work++;
      end
      if (style == 2) begin
        beat.cmd = CMD_DRAIN;
        beat.pixel = 8'($urandom);
        send_beat(beat, 1'b0, '0);
      end
      // a register write restarts whatever frame is left open
      if (style < 2) need_cfg = 1'b1;
    end

    gaps_on = 1'b0;
    stalls_on = 1'b0;
    settle();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gdil_pkg.sv
rtl/gdil_ram.sv
rtl/gdil_ctrl.sv
rtl/gdil_win.sv
rtl/grayscale_dilation_3x3.sv
verif/grayscale_dilation_3x3_tb.sv
